@@ rtl/vmmn_pkg.sv @@
package vmmn_pkg;

  localparam int IN_W   = 16;  // sample field width on the stream
  localparam int CFG_W  = 16;  // out_low / out_high width
  localparam int FRAC_W = 16;  // fraction bits of the scale factor
  localparam int Q_W    = 32;  // scale magnitude width
  localparam int NUM_W  = CFG_W + FRAC_W + 1;  // dividend width

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [0:0] REG_OUT_LOW  = 1'b0;
  localparam logic [0:0] REG_OUT_HIGH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FLAT = 2'd1,
    ST_PAST = 2'd2
  } status_t;

  typedef struct packed {
    logic           neg;
    logic [Q_W-1:0] mag;
  } scale_t;

endpackage

@@ rtl/vmmn_ram.sv @@
module vmmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/vmmn_div.sv @@
// Restoring divider, one quotient bit per cycle.
module vmmn_div #(
  parameter int SW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vmmn_pkg::NUM_W-1:0] num,
  input  logic [SW-1:0]              den,
  output logic                       busy,
  output logic                       done,
  output logic [vmmn_pkg::Q_W-1:0]   quot
);
  import vmmn_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] qn_r, qn_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [SW-1:0]    den_r, den_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SW:0]      trial;
  logic [SW:0]      diff;

  always_comb begin
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, qn_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      qn_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[SW-1:0];
        qn_nxt  = {qn_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SW-1:0];
        qn_nxt  = {qn_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  // quotient stays below 2^32, top bit is always zero
  assign quot = qn_r[Q_W-1:0];

endmodule

@@ rtl/vmmn_map.sv @@
// Scale multiply (registered) followed by round, offset and clamp.
module vmmn_map #(
  parameter int SW = 16
) (
  input  logic                       clk,
  input  logic                       mul_en,
  input  logic [SW-1:0]              smp,
  input  logic [SW-1:0]              vmin,
  input  vmmn_pkg::scale_t           scale,
  input  logic [vmmn_pkg::CFG_W-1:0] out_low,
  input  logic [vmmn_pkg::CFG_W-1:0] out_high,
  output logic [vmmn_pkg::CFG_W-1:0] value
);
  import vmmn_pkg::*;

  localparam int P_W   = Q_W + SW;
  localparam int RND_W = P_W + 1 - FRAC_W;
  localparam int V_W   = RND_W + 2;

  logic [P_W-1:0]        prod_r;
  logic [SW-1:0]         dx;
  logic [P_W:0]          psum;
  logic [RND_W-1:0]      rnd;
  logic signed [V_W-1:0] base, off, v, lo_s, hi_s;
  logic [CFG_W-1:0]      lo, hi;

  assign dx = smp - vmin;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= P_W'(scale.mag) * P_W'(dx);
    end
  end

  always_comb begin
    psum = {1'b0, prod_r} + (P_W + 1)'(1 << (FRAC_W - 1));
    rnd  = psum[P_W:FRAC_W];
    base = V_W'(out_low);
    off  = V_W'(rnd);
    v    = scale.neg ? base - off : base + off;
    lo   = (out_low < out_high) ? out_low : out_high;
    hi   = (out_low < out_high) ? out_high : out_low;
    lo_s = V_W'(lo);
    hi_s = V_W'(hi);
    if (v < lo_s) begin
      value = lo;
    end else if (v > hi_s) begin
      value = hi;
    end else begin
      value = v[CFG_W-1:0];
    end
  end

endmodule

@@ rtl/volume_min_max_normalizer_top.sv @@
// Volume min/max normalizer.
// Input beats: in_tuser selects load (0) or read (1); in_tdata carries the
// sample of a load. A load stores the sample in the voxel RAM and updates
// the running min/max; the first load after any read starts a new volume.
// Each read returns one beat on the out_ channel: the next stored sample
// mapped from [min,max] onto [out_low,out_high], rounded and clamped, with
// out_tlast on the final stored sample and out_tuser giving the status
// (ok, flat volume, read past end). Loads beyond MAX_VOXELS are dropped.
// Timing: a load is taken in S_IDLE. A read steps through RAM read, multiply
// and result register; the first read of a volume that is neither empty nor
// flat also runs the serial scale divider, one quotient bit per cycle. in_tready
// is low while a read is in flight.
// A finished result sits in the output register while a new input beat is
// accepted; a stalled receiver blocks only the next read at its last step.
// Reset (synchronous, active low) empties the volume and restores the
// target range to [0,65535]. The voxel RAM is not cleared.
module volume_min_max_normalizer_top #(
  parameter int MAX_VOXELS  = 16384,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,   // [15:0] sample
  input  logic [0:0]                 in_tuser,   // [0] opcode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // [15:0] value
  output logic                       out_tlast,
  output logic [1:0]                 out_tuser,  // [1:0] status
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_addr,
  input  logic [vmmn_pkg::CFG_W-1:0] cfg_wdata
);
  import vmmn_pkg::*;

  localparam int SW    = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int CNT_W = $clog2(MAX_VOXELS + 1);
  localparam int IDX_W = $clog2(MAX_VOXELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MEM,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rpos_r, rpos_nxt;
  logic [SW-1:0]    min_r, min_nxt;
  logic [SW-1:0]    max_r, max_nxt;
  scale_t           scale_r, scale_nxt;
  logic             scale_rdy_r, scale_rdy_nxt;
  logic             reading_r, reading_nxt;
  logic [CFG_W-1:0] out_low_r, out_low_nxt;
  logic [CFG_W-1:0] out_high_r, out_high_nxt;
  logic             ok_r, ok_nxt;
  logic             last_r, last_nxt;
  logic             flat_r, flat_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             in_fire;
  logic [SW-1:0]    smp;
  logic [CNT_W-1:0] eff_cnt;
  logic             ram_we, ram_re;
  logic [SW-1:0]    ram_rdata;
  logic             div_start, div_busy, div_done;
  logic [Q_W-1:0]   div_quot;
  logic [NUM_W-1:0] div_num;
  logic [SW-1:0]    range;
  logic             tgt_neg;
  logic [CFG_W-1:0] tgt_mag;
  logic             mul_en;
  logic [CFG_W-1:0] map_value;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign smp       = in_tdata[SW-1:0];
  // a load after a read restarts the volume at entry zero
  assign eff_cnt   = reading_r ? '0 : cnt_r;

  assign range   = max_r - min_r;
  assign tgt_neg = out_low_r > out_high_r;
  assign tgt_mag = tgt_neg ? out_low_r - out_high_r : out_high_r - out_low_r;
  assign div_num = {1'b0, tgt_mag, {FRAC_W{1'b0}}} + NUM_W'(range >> 1);

  vmmn_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_VOXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(eff_cnt[IDX_W-1:0]),
    .wdata(smp),
    .re   (ram_re),
    .raddr(rpos_r[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  vmmn_div #(
    .SW(SW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (range),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  vmmn_map #(
    .SW(SW)
  ) u_map (
    .clk     (clk),
    .mul_en  (mul_en),
    .smp     (ram_rdata),
    .vmin    (min_r),
    .scale   (scale_r),
    .out_low (out_low_r),
    .out_high(out_high_r),
    .value   (map_value)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rpos_nxt       = rpos_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    scale_nxt      = scale_r;
    scale_rdy_nxt  = scale_rdy_r;
    reading_nxt    = reading_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;
    ok_nxt         = ok_r;
    last_nxt       = last_r;
    flat_nxt       = flat_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    div_start      = 1'b0;
    mul_en         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == OP_LOAD) begin
            if (reading_r) begin
              rpos_nxt      = '0;
              scale_rdy_nxt = 1'b0;
              reading_nxt   = 1'b0;
              min_nxt       = '1;
              max_nxt       = '0;
            end
            if (eff_cnt < CNT_W'(MAX_VOXELS)) begin
              ram_we  = 1'b1;
              cnt_nxt = eff_cnt + CNT_W'(1);
              if (eff_cnt == '0) begin
                min_nxt = smp;
                max_nxt = smp;
              end else begin
                if (smp < min_r) min_nxt = smp;
                if (smp > max_r) max_nxt = smp;
              end
            end
          end else begin
            reading_nxt = 1'b1;
            ram_re      = 1'b1;
            ok_nxt      = rpos_r < cnt_r;
            last_nxt    = (rpos_r + CNT_W'(1)) == cnt_r;
            flat_nxt    = !(max_r > min_r);
            if (rpos_r < cnt_r) begin
              rpos_nxt = rpos_r + CNT_W'(1);
            end
            if (!scale_rdy_r) begin
              scale_rdy_nxt = 1'b1;
              if (cnt_r == '0 || !(max_r > min_r)) begin
                scale_nxt = '0;
                state_nxt = S_MEM;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end else begin
              state_nxt = S_MEM;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          scale_nxt.mag = div_quot;
          scale_nxt.neg = tgt_neg;
          state_nxt     = S_MEM;
        end
      end
      S_MEM: begin
        mul_en    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (!ok_r) begin
            out_value_nxt  = '0;
            out_last_nxt   = 1'b0;
            out_status_nxt = ST_PAST;
          end else if (flat_r) begin
            out_value_nxt  = out_low_r;
            out_last_nxt   = last_r;
            out_status_nxt = ST_FLAT;
          end else begin
            out_value_nxt  = map_value;
            out_last_nxt   = last_r;
            out_status_nxt = ST_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_addr)
        REG_OUT_LOW:  out_low_nxt  = cfg_wdata;
        REG_OUT_HIGH: out_high_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      rpos_r       <= '0;
      min_r        <= '1;
      max_r        <= '0;
      scale_r      <= '0;
      scale_rdy_r  <= 1'b0;
      reading_r    <= 1'b0;
      out_low_r    <= '0;
      out_high_r   <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rpos_r       <= rpos_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      scale_r      <= scale_nxt;
      scale_rdy_r  <= scale_rdy_nxt;
      reading_r    <= reading_nxt;
      out_low_r    <= out_low_nxt;
      out_high_r   <= out_high_nxt;
      out_valid_r  <= out_valid_nxt;
      ok_r         <= ok_nxt;
      last_r       <= last_nxt;
      flat_r       <= flat_nxt;
      out_value_r  <= out_value_nxt;
      out_last_r   <= out_last_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  a_rpos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rpos_r <= cnt_r)
    else $error("read position beyond stored count");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VOXELS))
    else $error("stored count beyond capacity");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider running outside divide state");

  a_past_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_PAST) |-> !out_last_r)
    else $error("read past end marked last");

endmodule
